// ===== design/ipv4_pkg.sv =====
// Shared types, constants and a helper function for the IPv4 address/mask text parser.
package ipv4_pkg;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Limits
    localparam logic [9:0]  OCTET_MAX  = 10'd255;
    localparam logic [5:0]  PREFIX_MAX = 6'd32;
    localparam logic [5:0]  CIDR_SAT   = 6'd33;
    localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;

    // Output item layout
    localparam int M_TDATA_W = 48;

    // Parse modes
    localparam logic MODE_ADDR = 1'b0;
    localparam logic MODE_MASK = 1'b1;

    typedef enum logic [1:0] {
        PH_START,
        PH_SLASH,
        PH_DIGITS,
        PH_FAIL
    } cidr_phase_t;

    typedef enum logic [3:0] {
        CLS_PUBLIC,
        CLS_PRIV10,
        CLS_PRIV172,
        CLS_PRIV192,
        CLS_LOOPBACK,
        CLS_MULTICAST,
        CLS_BROADCAST,
        CLS_RSV0,
        CLS_RSV240
    } addr_class_t;

    // Parse state captured when a terminator is accepted
    typedef struct packed {
        logic        mode;
        logic        dq_ok;
        logic [31:0] dq_val;
        logic        cidr_ok;
        logic [5:0]  cidr_value;
    } snap_t;

    // Address class, checked in priority order
    function automatic addr_class_t classify(input logic [31:0] ip);
        logic [7:0]  a;
        logic [7:0]  b;
        addr_class_t cls;
        a = ip[31:24];
        b = ip[23:16];
        if (a == 8'd10) begin
            cls = CLS_PRIV10;
        end else if (a == 8'd172 && (b inside {[8'd16:8'd31]})) begin
            cls = CLS_PRIV172;
        end else if (a == 8'd192 && b == 8'd168) begin
            cls = CLS_PRIV192;
        end else if (a == 8'd127) begin
            cls = CLS_LOOPBACK;
        end else if (a inside {[8'd224:8'd239]}) begin
            cls = CLS_MULTICAST;
        end else if (ip == ALL_ONES) begin
            cls = CLS_BROADCAST;
        end else if (a == 8'd0) begin
            cls = CLS_RSV0;
        end else if (a >= 8'd240) begin
            cls = CLS_RSV240;
        end else begin
            cls = CLS_PUBLIC;
        end
        return cls;
    endfunction

endpackage

// ===== design/ipv4_address_mask_text_parser.sv =====
// Top level: IPv4 dotted-quad address and CIDR/netmask text parser, one character per item.
// A terminator item's result shows on m_tvalid after it passes the snapshot register, then the
//   output register; other characters give no result.
// Throughput: one character per cycle while output back-pressure does not hold s_tready low.
// Reset: synchronous active-low aresetn clears parse state, sets address mode, empties both stages.
module ipv4_address_mask_text_parser (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_data,   // [0] parse_mode
    // character input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,    // [7:0] char_code
    // result output
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ipv4_pkg::M_TDATA_W-1:0] m_tdata,    // [31:0] value, [37:32] prefix_length,
                                                       // [41:38] address_class, [47:42] zero
    output logic                           m_tuser     // [0] valid_res
);
    import ipv4_pkg::*;

    logic  mode_reg, mode_next;
    logic  snap_valid;
    snap_t snap;
    logic  snap_take;

    // Mode register
    assign cfg_ready = 1'b1;
    assign mode_next = (cfg_valid && cfg_ready) ? cfg_data : mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_ADDR;
        end else begin
            mode_reg <= mode_next;
        end
    end

    ipv4_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .mode       (mode_reg),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_take  (snap_take)
    );

    ipv4_result u_result (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_take  (snap_take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    // A rejected string carries an all-zero payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("rejected result with nonzero payload");

    // Prefix length never exceeds 32
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[37:32] <= PREFIX_MAX)
        else $error("prefix length out of range");

    // Class and prefix length are never both set
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[41:38] != CLS_PUBLIC |-> m_tdata[37:32] == 6'd0)
        else $error("class and prefix both set");

    // A rising result valid needs a valid terminator snapshot before it
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(snap_valid))
        else $error("result without a snapshot");

    // Pipeline is empty after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

// ===== design/ipv4_parser.sv =====
// Per-character parse state for the dotted-quad and CIDR recognizers, plus terminator snapshot.
module ipv4_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,      // [7:0] char_code
    input  logic             mode,
    output logic             snap_valid,
    output ipv4_pkg::snap_t  snap,
    input  logic             snap_take
);
    import ipv4_pkg::*;

    // Parse state
    logic [1:0]  octet_index_reg,  octet_index_next;
    logic [1:0]  digit_count_reg,  digit_count_next;
    logic [9:0]  octet_value_reg,  octet_value_next;
    logic [23:0] addr_acc_reg,     addr_acc_next;
    logic        dotted_failed_reg, dotted_failed_next;
    cidr_phase_t cidr_phase_reg,   cidr_phase_next;
    logic [5:0]  cidr_value_reg,   cidr_value_next;

    // Snapshot stage
    logic        snap_valid_reg, snap_valid_next;
    snap_t       snap_reg,       snap_next;

    logic        snap_adv;
    logic        accept;
    logic        is_term;
    logic        is_digit;
    logic [3:0]  digit;
    logic [9:0]  octet_dig;
    logic [8:0]  cidr_prod;
    logic [5:0]  cidr_dig;

    // Snapshot slot frees when empty or when downstream takes it
    assign snap_adv = !snap_valid_reg || snap_take;
    assign s_tready = snap_adv;
    assign accept   = s_tvalid && s_tready;

    assign is_term  = (s_tdata == CH_NUL);
    assign is_digit = (s_tdata inside {[CH_ZERO:CH_NINE]});
    assign digit    = s_tdata[3:0];

    // Times ten plus digit; octet stays below 1000 while fewer than 3 digits
    assign octet_dig = (octet_value_reg << 3) + (octet_value_reg << 1) + 10'(digit);
    assign cidr_prod = {cidr_value_reg, 3'b000} + {2'b00, cidr_value_reg, 1'b0} + 9'(digit);
    assign cidr_dig  = (cidr_prod > 9'(PREFIX_MAX)) ? CIDR_SAT : cidr_prod[5:0];

    // Next parse state
    always_comb begin
        octet_index_next   = octet_index_reg;
        digit_count_next   = digit_count_reg;
        octet_value_next   = octet_value_reg;
        addr_acc_next      = addr_acc_reg;
        dotted_failed_next = dotted_failed_reg;
        cidr_phase_next    = cidr_phase_reg;
        cidr_value_next    = cidr_value_reg;

        if (accept && is_term) begin
            octet_index_next   = 2'd0;
            digit_count_next   = 2'd0;
            octet_value_next   = 10'd0;
            addr_acc_next      = 24'd0;
            dotted_failed_next = 1'b0;
            cidr_phase_next    = PH_START;
            cidr_value_next    = 6'd0;
        end else if (accept) begin
            // dotted quad
            if (!dotted_failed_reg) begin
                if (is_digit) begin
                    if (digit_count_reg == 2'd3) begin
                        dotted_failed_next = 1'b1;
                    end else begin
                        octet_value_next = octet_dig;
                        digit_count_next = digit_count_reg + 2'd1;
                    end
                end else if (s_tdata == CH_DOT) begin
                    if (digit_count_reg == 2'd0 || octet_value_reg > OCTET_MAX ||
                        octet_index_reg == 2'd3) begin
                        dotted_failed_next = 1'b1;
                    end else begin
                        addr_acc_next    = {addr_acc_reg[15:0], octet_value_reg[7:0]};
                        octet_index_next = octet_index_reg + 2'd1;
                        digit_count_next = 2'd0;
                        octet_value_next = 10'd0;
                    end
                end else begin
                    dotted_failed_next = 1'b1;
                end
            end

            // CIDR
            case (cidr_phase_reg)
                PH_START: begin
                    if (s_tdata == CH_SLASH) begin
                        cidr_phase_next = PH_SLASH;
                    end else if (is_digit) begin
                        cidr_phase_next = PH_DIGITS;
                        cidr_value_next = 6'(digit);
                    end else begin
                        cidr_phase_next = PH_FAIL;
                    end
                end
                PH_SLASH: begin
                    if (is_digit) begin
                        cidr_phase_next = PH_DIGITS;
                        cidr_value_next = 6'(digit);
                    end else begin
                        cidr_phase_next = PH_FAIL;
                    end
                end
                PH_DIGITS: begin
                    if (is_digit) begin
                        cidr_value_next = cidr_dig;
                    end else begin
                        cidr_phase_next = PH_FAIL;
                    end
                end
                default: begin
                    cidr_phase_next = PH_FAIL;
                end
            endcase
        end
    end

    // Snapshot of the finished string
    always_comb begin
        snap_valid_next = snap_valid_reg;
        snap_next       = snap_reg;
        if (snap_adv) begin
            snap_valid_next    = accept && is_term;
            snap_next.mode     = mode;
            snap_next.dq_ok    = !dotted_failed_reg && octet_index_reg == 2'd3 &&
                                 digit_count_reg != 2'd0 && octet_value_reg <= OCTET_MAX;
            snap_next.dq_val   = {addr_acc_reg, octet_value_reg[7:0]};
            snap_next.cidr_ok  = (cidr_phase_reg == PH_DIGITS) && (cidr_value_reg <= PREFIX_MAX);
            snap_next.cidr_value = cidr_value_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            octet_index_reg   <= 2'd0;
            digit_count_reg   <= 2'd0;
            octet_value_reg   <= 10'd0;
            addr_acc_reg      <= 24'd0;
            dotted_failed_reg <= 1'b0;
            cidr_phase_reg    <= PH_START;
            cidr_value_reg    <= 6'd0;
            snap_valid_reg    <= 1'b0;
        end else begin
            octet_index_reg   <= octet_index_next;
            digit_count_reg   <= digit_count_next;
            octet_value_reg   <= octet_value_next;
            addr_acc_reg      <= addr_acc_next;
            dotted_failed_reg <= dotted_failed_next;
            cidr_phase_reg    <= cidr_phase_next;
            cidr_value_reg    <= cidr_value_next;
            snap_valid_reg    <= snap_valid_next;
        end
    end

    // Snapshot payload, no reset
    always_ff @(posedge aclk) begin
        snap_reg <= snap_next;
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

// ===== design/ipv4_result.sv =====
// Result formation from the terminator snapshot: validity, value, prefix length, class; output register.
module ipv4_result (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           snap_valid,
    input  ipv4_pkg::snap_t                snap,
    output logic                           snap_take,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ipv4_pkg::M_TDATA_W-1:0] m_tdata,  // [31:0] value, [37:32] prefix_length,
                                                     // [41:38] address_class, [47:42] zero
    output logic                           m_tuser   // [0] valid_res
);
    import ipv4_pkg::*;

    logic                 out_valid_reg, out_valid_next;
    logic                 res_ok_reg,    res_ok_next;
    logic [31:0]          value_reg,     value_next;
    logic [5:0]           prefix_reg,    prefix_next;
    addr_class_t          class_reg,     class_next;

    logic                 out_adv;
    logic [31:0]          inv;
    logic [32:0]          inv_inc;
    logic                 contiguous;
    logic [5:0]           low_pos;
    logic [31:0]          cidr_mask;

    assign out_adv   = !out_valid_reg || m_tready;
    assign snap_take = out_adv;

    // Contiguous mask: ~m + 1 is a single bit at the first zero above the ones
    assign inv        = ~snap.dq_val;
    assign inv_inc    = {1'b0, inv} + 33'd1;
    assign contiguous = ((inv & inv_inc[31:0]) == 32'd0);

    // Encode position of that single bit
    always_comb begin
        low_pos = 6'd0;
        for (int i = 0; i <= 32; i++) begin
            if (inv_inc[i]) begin
                low_pos = low_pos | 6'(i);
            end
        end
    end

    // Prefix to mask; a shift of 32 gives zero
    assign cidr_mask = ALL_ONES << (6'd32 - snap.cidr_value);

    // Result selection
    always_comb begin
        res_ok_next = 1'b0;
        value_next  = 32'd0;
        prefix_next = 6'd0;
        class_next  = CLS_PUBLIC;
        if (snap.mode == MODE_ADDR) begin
            if (snap.dq_ok) begin
                res_ok_next = 1'b1;
                value_next  = snap.dq_val;
                class_next  = classify(snap.dq_val);
            end
        end else begin
            if (snap.cidr_ok) begin
                res_ok_next = 1'b1;
                value_next  = cidr_mask;
                prefix_next = snap.cidr_value;
            end else if (snap.dq_ok && contiguous) begin
                res_ok_next = 1'b1;
                value_next  = snap.dq_val;
                prefix_next = PREFIX_MAX - low_pos;
            end
        end
    end

    assign out_valid_next = out_adv ? snap_valid : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload, loaded when the register can advance
    always_ff @(posedge aclk) begin
        if (out_adv) begin
            res_ok_reg <= res_ok_next;
            value_reg  <= value_next;
            prefix_reg <= prefix_next;
            class_reg  <= class_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_ok_reg;
    assign m_tdata  = {6'd0, class_reg, prefix_reg, value_reg};

endmodule
